[hdl/indexed_bucket_priority_queue_assert.svh]
// assertion macros for the bucket queue checker
// no dependencies
`ifndef INDEXED_BUCKET_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_BUCKET_PRIORITY_QUEUE_ASSERT_SVH
`define IBPQ_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ibpq check failed");
`define IBPQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ibpq check failed");
`endif

[hdl/ibpq_pkg.sv]
// shared types and constants for the bucket priority queue
// no dependencies
package ibpq_pkg;
    localparam int NumElements = 1024;
    localparam int NumBuckets = 256;
    localparam int EW = $clog2(NumElements);
    localparam int BW = $clog2(NumBuckets);
    localparam int CW = EW + 1;

    typedef logic [EW-1:0] elem_t;
    typedef logic [BW-1:0] bkt_t;
    typedef logic [CW-1:0] cnt_t;

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_POP_MIN = 3'd1;
    localparam logic [2:0] OP_POP_MAX = 3'd2;
    localparam logic [2:0] OP_MOVE = 3'd3;
    localparam logic [2:0] OP_PEEK_MIN = 3'd4;
    localparam logic [2:0] OP_PEEK_MAX = 3'd5;
    localparam logic [2:0] OP_LOOKUP = 3'd6;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;
endpackage

[hdl/indexed_bucket_priority_queue.sv]
// bucket priority queue top level: link memories, occupancy bitmap, sequencer
// depends on ibpq_pkg
//
// usage: one request word on the in channel (opcode, element_id, bucket_index),
// one response word on the out channel (status, result_element, result_bucket,
// is_present, element_count, is_empty). both channels are valid/stall.
// the block takes one request at a time. lookup, peek and rejected requests
// are answered after the decode of the map and top reads; push links the new
// element on top of its bucket; pop and move unlink the element and rescan the
// bounds by walking the occupancy bitmap one bucket per cycle, and move then
// pushes it again. the next request is taken only after the response word has
// been accepted. element links and bucket tops live in single-port
// synchronous memories with registered reads; every read-modify-write goes
// through them in turn. after reset the element map is swept clear, and
// in_stall stays high during the sweep. while the receiver stalls, the
// response word holds and no new request is taken.
module indexed_bucket_priority_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            opcode,
    input  ibpq_pkg::elem_t       element_id,
    input  ibpq_pkg::bkt_t        bucket_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output ibpq_pkg::elem_t       result_element,
    output ibpq_pkg::bkt_t        result_bucket,
    output logic                  is_present,
    output ibpq_pkg::cnt_t        element_count,
    output logic                  is_empty
);
    import ibpq_pkg::*;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_DEC = 4'd3,
        S_UL1 = 4'd4, S_UL2 = 4'd5, S_UL3 = 4'd6, S_SCAN = 4'd7, S_PUSH = 4'd8,
        S_PUSH2 = 4'd9, S_DONE = 4'd10, S_TOPRD = 4'd11, S_PUSH3 = 4'd12;

    // memories: map holds bucket+1 (0 absent), links hold neighbour with a none bit
    logic [BW:0] map_mem [NumElements];
    logic [EW:0] dn_mem [NumElements];
    logic [EW:0] up_mem [NumElements];
    elem_t top_mem [NumBuckets];
    logic [NumBuckets-1:0] occ_reg;

    logic [3:0] state_reg;
    logic [2:0] op_reg;
    elem_t e_reg, t_reg;
    bkt_t b_reg, ob_reg, sb_reg;
    logic [BW:0] map_q, lo_reg, hi_reg, scan_lo, scan_hi;
    logic [EW:0] dn_q, up_q, below_reg, above_reg;
    elem_t top_q;
    logic [BW:0] scan_reg;
    cnt_t cnt_reg;
    logic [EW:0] clr_reg;

    // memory request lines, driven by the sequencer
    logic map_we, dn_we, up_we, top_we;
    elem_t map_a, dn_a, up_a;
    bkt_t top_a;
    logic [BW:0] map_d;
    logic [EW:0] dn_d, up_d;
    elem_t top_d;

    always_ff @(posedge clk)
    begin
        if (map_we) map_mem[map_a] <= map_d;
        map_q <= map_mem[map_a];
        if (dn_we) dn_mem[dn_a] <= dn_d;
        dn_q <= dn_mem[dn_a];
        if (up_we) up_mem[up_a] <= up_d;
        up_q <= up_mem[up_a];
        if (top_we) top_mem[top_a] <= top_d;
        top_q <= top_mem[top_a];
    end

    wire is_pop = (op_reg == OP_POP_MIN) || (op_reg == OP_POP_MAX);
    wire is_min = (op_reg == OP_POP_MIN) || (op_reg == OP_PEEK_MIN);

    always_comb
    begin
        map_we = 1'b0; dn_we = 1'b0; up_we = 1'b0; top_we = 1'b0;
        map_a = e_reg; dn_a = e_reg; up_a = e_reg; top_a = sb_reg;
        map_d = '0; dn_d = '0; up_d = '0; top_d = '0;
        case (state_reg)
            S_CLR:
            begin
                map_we = 1'b1;
                map_a = clr_reg[EW-1:0];
            end
            S_IDLE:
            begin
                map_a = element_id;
                top_a = is_min ? lo_reg[BW-1:0] : hi_reg[BW-1:0];
            end
            S_UL1:
            begin
                // clear map entry and fetch neighbours of t
                map_we = 1'b1;
                map_a = t_reg;
                dn_a = t_reg;
                up_a = t_reg;
            end
            S_UL2:
            begin
                if (up_q[EW])
                begin
                    top_we = 1'b1;
                    top_a = ob_reg;
                    top_d = dn_q[EW-1:0];
                end
                else
                begin
                    dn_we = 1'b1;
                    dn_a = up_q[EW-1:0];
                    dn_d = dn_q;
                end
            end
            S_UL3:
            begin
                if (!below_reg[EW])
                begin
                    up_we = 1'b1;
                    up_a = below_reg[EW-1:0];
                    up_d = above_reg;
                end
            end
            S_PUSH:
            begin
                top_a = b_reg;
            end
            S_PUSH2:
            begin
                dn_we = 1'b1;
                dn_d = occ_reg[b_reg] ? {1'b0, top_q} : {1'b1, elem_t'(0)};
                // old top points up to e, or e is alone and has nothing above
                up_we = 1'b1;
                if (occ_reg[b_reg])
                begin
                    up_a = top_q;
                    up_d = {1'b0, e_reg};
                end
                else
                    up_d = {1'b1, elem_t'(0)};
                top_we = 1'b1;
                top_a = b_reg;
                top_d = e_reg;
                map_we = 1'b1;
                map_d = {1'b0, b_reg} + 1'b1;
            end
            S_PUSH3:
            begin
                // e is the new top: nothing above it
                up_we = 1'b1;
                up_d = {1'b1, elem_t'(0)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            occ_reg <= '0;
            lo_reg <= {1'b1, bkt_t'(0)};
            hi_reg <= {1'b1, bkt_t'(0)};
            cnt_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == cnt_t'(NumElements - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= opcode;
                        e_reg <= element_id;
                        b_reg <= bucket_index;
                        sb_reg <= (opcode == OP_POP_MIN || opcode == OP_PEEK_MIN)
                            ? lo_reg[BW-1:0] : hi_reg[BW-1:0];
                        status <= ST_OK;
                        result_element <= '0;
                        result_bucket <= '0;
                        is_present <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD: state_reg <= S_DEC;
                S_DEC:
                begin
                    case (op_reg)
                        OP_PUSH:
                            if (map_q != '0)
                            begin
                                status <= ST_PRESENT;
                                state_reg <= S_DONE;
                            end
                            else state_reg <= S_PUSH;
                        OP_MOVE:
                            if (map_q == '0)
                            begin
                                status <= ST_ABSENT;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                t_reg <= e_reg;
                                ob_reg <= map_q[BW-1:0] - 1'b1;
                                state_reg <= S_UL1;
                            end
                        OP_LOOKUP:
                        begin
                            if (map_q != '0)
                            begin
                                is_present <= 1'b1;
                                result_bucket <= map_q[BW-1:0] - 1'b1;
                            end
                            state_reg <= S_DONE;
                        end
                        OP_POP_MIN, OP_POP_MAX, OP_PEEK_MIN, OP_PEEK_MAX:
                            if (cnt_reg == '0)
                            begin
                                status <= ST_EMPTY;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                result_element <= top_q;
                                result_bucket <= sb_reg;
                                if (is_pop)
                                begin
                                    t_reg <= top_q;
                                    ob_reg <= sb_reg;
                                    state_reg <= S_UL1;
                                end
                                else state_reg <= S_DONE;
                            end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_UL1: state_reg <= S_UL2;
                S_UL2:
                begin
                    below_reg <= dn_q;
                    above_reg <= up_q;
                    if (up_q[EW] && dn_q[EW]) occ_reg[ob_reg] <= 1'b0;
                    state_reg <= S_UL3;
                end
                S_UL3:
                begin
                    scan_reg <= '0;
                    scan_lo <= {1'b1, bkt_t'(0)};
                    scan_hi <= {1'b1, bkt_t'(0)};
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (occ_reg[scan_reg[BW-1:0]])
                    begin
                        if (scan_lo[BW]) scan_lo <= scan_reg;
                        scan_hi <= scan_reg;
                    end
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg[BW-1:0] == bkt_t'(NumBuckets - 1))
                        state_reg <= S_TOPRD;
                end
                S_TOPRD:
                begin
                    lo_reg <= scan_lo;
                    hi_reg <= scan_hi;
                    if (op_reg == OP_MOVE) state_reg <= S_PUSH;
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_PUSH: state_reg <= S_PUSH2;
                S_PUSH2:
                begin
                    occ_reg[b_reg] <= 1'b1;
                    if (lo_reg[BW] || {1'b0, b_reg} < lo_reg) lo_reg <= {1'b0, b_reg};
                    if (hi_reg[BW] || {1'b0, b_reg} > hi_reg) hi_reg <= {1'b0, b_reg};
                    if (op_reg == OP_PUSH) cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= S_PUSH3;
                end
                S_PUSH3: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                        element_count <= cnt_reg;
                        is_empty <= cnt_reg == '0;
                        if (cnt_reg == '0)
                        begin
                            lo_reg <= {1'b1, bkt_t'(0)};
                            hi_reg <= {1'b1, bkt_t'(0)};
                        end
                    end
                    else if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall = state_reg != S_IDLE;
endmodule

[hdl/ibpq_checker.sv]
// port-level checker for the bucket priority queue, bound to the top level
// depends on ibpq_pkg and the assertion macro header
`include "indexed_bucket_priority_queue_assert.svh"
module ibpq_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic [1:0] status,
    input ibpq_pkg::cnt_t element_count,
    input logic is_empty
);
    import ibpq_pkg::*;
    `IBPQ_ASSERT_IMP(empty_matches_count, clk, rst_n, out_valid,
        is_empty == (element_count == '0))
    `IBPQ_ASSERT_IMP(count_in_range, clk, rst_n, out_valid,
        element_count <= cnt_t'(NumElements))
    `IBPQ_ASSERT_IMP(busy_while_reply, clk, rst_n, out_valid, in_stall)
    `IBPQ_ASSERT_NEXT(reply_holds, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status))
endmodule

bind indexed_bucket_priority_queue ibpq_checker u_ibpq_checker (.*);

[tb/indexed_bucket_priority_queue_test.sv]
// testbench for the bucket priority queue: directed and random request words,
// an in-bench model of the buckets, and a response checker. depends on ibpq_pkg
module indexed_bucket_priority_queue_test;
    import ibpq_pkg::*;

    localparam int NO_LINK = NumElements;
    localparam int NO_BKT = NumBuckets;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        elem_t      elem;
        bkt_t       bkt;
    } request_t;

    typedef struct packed {
        logic [1:0] st;
        elem_t      elem;
        bkt_t       bkt;
        logic       present;
        cnt_t       count;
        logic       empty;
    } response_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [2:0] opcode = '0;
    elem_t element_id = '0;
    bkt_t bucket_index = '0;
    logic out_valid;
    logic out_stall = 0;
    logic [1:0] status;
    elem_t result_element;
    bkt_t result_bucket;
    logic is_present;
    cnt_t element_count;
    logic is_empty;

    indexed_bucket_priority_queue dut (.*);

    // bucket model state
    int home[NumElements];       // bucket+1, 0 when absent
    int below_of[NumElements];
    int above_of[NumElements];
    int top_of[NumBuckets];
    bit occupied[NumBuckets];
    int low_bkt, high_bkt, held;

    request_t pending_words[$];
    response_t expected_words[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    bit calm = 0;            // no idling in the last part
    bit hold_off = 0;
    bit in_taken = 0;        // word on the in channel accepted at the last rising edge
    int op_seen[8];

    function automatic void rescan();
        low_bkt = NO_BKT;
        high_bkt = NO_BKT;
        for (int b = 0; b < NumBuckets; b++)
            if (occupied[b])
            begin
                if (low_bkt == NO_BKT) low_bkt = b;
                high_bkt = b;
            end
    endfunction

    function automatic void place_on_top(int e, int b);
        if (occupied[b])
        begin
            below_of[e] = top_of[b];
            above_of[top_of[b]] = e;
        end
        else
            below_of[e] = NO_LINK;
        above_of[e] = NO_LINK;
        top_of[b] = e;
        occupied[b] = 1;
        home[e] = b + 1;
        if (low_bkt == NO_BKT || b < low_bkt) low_bkt = b;
        if (high_bkt == NO_BKT || b > high_bkt) high_bkt = b;
    endfunction

    function automatic void take_out(int e, int b);
        int dn, up;
        dn = below_of[e];
        up = above_of[e];
        if (up >= NO_LINK) top_of[b] = dn;
        else below_of[up] = dn;
        if (dn < NO_LINK) above_of[dn] = up;
        if (top_of[b] >= NO_LINK) occupied[b] = 0;
        home[e] = 0;
    endfunction

    function automatic response_t queue_step(request_t w);
        response_t r;
        int e, b, sb, t;
        bit found;
        r = '0;
        e = w.elem;
        b = w.bkt;
        found = home[e] != 0;
        case (w.op)
            OP_PUSH:
                if (found) r.st = ST_PRESENT;
                else
                begin
                    place_on_top(e, b);
                    held++;
                end
            OP_POP_MIN, OP_POP_MAX, OP_PEEK_MIN, OP_PEEK_MAX:
                if (held == 0 || low_bkt >= NO_BKT) r.st = ST_EMPTY;
                else
                begin
                    sb = (w.op == OP_POP_MIN || w.op == OP_PEEK_MIN) ? low_bkt : high_bkt;
                    t = top_of[sb];
                    r.elem = elem_t'(t);
                    r.bkt = bkt_t'(sb);
                    if (w.op == OP_POP_MIN || w.op == OP_POP_MAX)
                    begin
                        take_out(t, sb);
                        held--;
                        rescan();
                    end
                end
            OP_MOVE:
                if (!found) r.st = ST_ABSENT;
                else
                begin
                    take_out(e, home[e] - 1);
                    rescan();
                    place_on_top(e, b);
                end
            OP_LOOKUP:
                if (found)
                begin
                    r.present = 1;
                    r.bkt = bkt_t'(home[e] - 1);
                end
            default: ;
        endcase
        if (held == 0)
        begin
            low_bkt = NO_BKT;
            high_bkt = NO_BKT;
        end
        r.count = cnt_t'(held);
        r.empty = held == 0;
        return r;
    endfunction

    function automatic request_t make_word(logic [2:0] op, int e, int b);
        request_t w;
        w.op = op;
        w.elem = elem_t'(e);
        w.bkt = bkt_t'(b);
        return w;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver: random gaps between words, no gaps once calm
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 0;
            end
            else if (pending_words.size() > 0 && (calm || $urandom_range(0, 5) != 0))
            begin
                request_t w;
                w = pending_words.pop_front();
                opcode <= w.op;
                element_id <= w.elem;
                bucket_index <= w.bkt;
                in_valid <= 1;
            end
            else
            begin
                in_valid <= 0;
                if (!calm && pending_words.size() > 0) gap_left <= $urandom_range(0, 16);
            end
        end
    end

    // record accepted words into the model
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            request_t w;
            w = make_word(opcode, element_id, bucket_index);
            expected_words.push_back(queue_step(w));
            op_seen[w.op]++;
            sent++;
        end
    end

    // receiver stall bursts, and one long hold-off on request
    int stall_left = 0;
    int hold_left = 0;
    bit hold_started = 0;
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1;
        end
        else if (hold_off && !hold_started)
        begin
            hold_started <= 1;
            hold_left <= 399;
            out_stall <= 1;
        end
        else if (calm) out_stall <= 0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall <= 1;
        end
        else out_stall <= 0;
    end

    // monitor
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            response_t x;
            received++;
            if (expected_words.size() == 0)
            begin
                $error("response word with nothing expected");
                errors++;
            end
            else
            begin
                x = expected_words.pop_front();
                if (status !== x.st)
                begin
                    $error("status expected %0d actual %0d", x.st, status);
                    errors++;
                end
                if (result_element !== x.elem)
                begin
                    $error("result_element expected %0d actual %0d", x.elem, result_element);
                    errors++;
                end
                if (result_bucket !== x.bkt)
                begin
                    $error("result_bucket expected %0d actual %0d", x.bkt, result_bucket);
                    errors++;
                end
                if (is_present !== x.present)
                begin
                    $error("is_present expected %0d actual %0d", x.present, is_present);
                    errors++;
                end
                if (element_count !== x.count)
                begin
                    $error("element_count expected %0d actual %0d", x.count, element_count);
                    errors++;
                end
                if (is_empty !== x.empty)
                begin
                    $error("is_empty expected %0d actual %0d", x.empty, is_empty);
                    errors++;
                end
            end
        end

    // random word: biased toward a small working set so moves and pops hit held ids
    function automatic request_t random_word(int pool);
        int r, e, b;
        logic [2:0] op;
        r = $urandom_range(0, 99);
        if (r < 35) op = OP_PUSH;
        else if (r < 47) op = OP_POP_MIN;
        else if (r < 59) op = OP_POP_MAX;
        else if (r < 75) op = OP_MOVE;
        else if (r < 81) op = OP_PEEK_MIN;
        else if (r < 87) op = OP_PEEK_MAX;
        else if (r < 98) op = OP_LOOKUP;
        else op = OP_UNUSED;
        e = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NumElements - 1)
                                        : $urandom_range(0, pool - 1);
        b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NumBuckets - 1)
                                        : $urandom_range(0, 15) * 17 % NumBuckets;
        return make_word(op, e, b);
    endfunction

    initial
    begin
        for (int i = 0; i < NumElements; i++) home[i] = 0;
        for (int i = 0; i < NumBuckets; i++) occupied[i] = 0;
        low_bkt = NO_BKT;
        high_bkt = NO_BKT;
        held = 0;

        // directed: empty queue cases, extremes, lifo order, unlink from middle
        pending_words.push_back(make_word(OP_POP_MIN, 0, 0));
        pending_words.push_back(make_word(OP_PEEK_MAX, 0, 0));
        pending_words.push_back(make_word(OP_MOVE, 5, 3));
        pending_words.push_back(make_word(OP_LOOKUP, 1023, 0));
        pending_words.push_back(make_word(OP_PUSH, 0, 0));
        pending_words.push_back(make_word(OP_PUSH, 1023, 255));
        pending_words.push_back(make_word(OP_PUSH, 1023, 4));
        pending_words.push_back(make_word(OP_PUSH, 10, 100));
        pending_words.push_back(make_word(OP_PUSH, 11, 100));
        pending_words.push_back(make_word(OP_PUSH, 12, 100));
        pending_words.push_back(make_word(OP_MOVE, 11, 7));
        pending_words.push_back(make_word(OP_MOVE, 12, 100));
        pending_words.push_back(make_word(OP_LOOKUP, 11, 0));
        pending_words.push_back(make_word(OP_PEEK_MIN, 0, 0));
        pending_words.push_back(make_word(OP_PEEK_MAX, 0, 0));
        pending_words.push_back(make_word(OP_UNUSED, 1023, 255));
        pending_words.push_back(make_word(OP_POP_MAX, 0, 0));
        pending_words.push_back(make_word(OP_POP_MIN, 0, 0));
        pending_words.push_back(make_word(OP_POP_MAX, 0, 0));
        pending_words.push_back(make_word(OP_POP_MAX, 0, 0));
        pending_words.push_back(make_word(OP_POP_MIN, 0, 0));
        pending_words.push_back(make_word(OP_POP_MIN, 0, 0));
        pending_words.push_back(make_word(OP_POP_MIN, 0, 0));

        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1;

        // element map sweep keeps in_stall up; wait on the handshake instead
        wait (pending_words.size() == 0);
        for (int i = 0; i < 300; i++) pending_words.push_back(random_word(24));

        // long receiver hold-off while the sender keeps offering
        wait (pending_words.size() < 290);
        hold_off = 1;
        wait (hold_started && hold_left == 0);
        hold_off = 0;

        for (int i = 0; i < 1300; i++) pending_words.push_back(random_word(i < 600 ? 64 : 300));
        wait (pending_words.size() == 0);
        calm = 1;
        for (int i = 0; i < 330; i++) pending_words.push_back(random_word(40));
        wait (pending_words.size() == 0);
        wait (expected_words.size() == 0 && !in_valid);
        repeat (2 * NumBuckets + 50) @(posedge clk);

        $display("ran %0d request words (%0d responses): push %0d, pops %0d, moves %0d,",
                 sent, received, op_seen[OP_PUSH], op_seen[OP_POP_MIN] + op_seen[OP_POP_MAX],
                 op_seen[OP_MOVE]);
        $display("peeks %0d, lookups %0d, idle opcode %0d; queue held %0d at the end",
                 op_seen[OP_PEEK_MIN] + op_seen[OP_PEEK_MAX], op_seen[OP_LOOKUP],
                 op_seen[OP_UNUSED], held);
        if (errors == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("Verification failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+hdl
hdl/ibpq_pkg.sv
hdl/indexed_bucket_priority_queue.sv
hdl/ibpq_checker.sv
tb/indexed_bucket_priority_queue_test.sv
